// ----- design/bsh_pkg.sv -----
// ----------------------------------------------------------------------------
// bsh_pkg: shared types and constants of the backend selector
// Operation codes, register map, item token and result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bsh_pkg;

  // operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_PICK   = 2'd0,
    OP_HEALTH = 2'd1,
    OP_OPEN   = 2'd2,
    OP_CLOSE  = 2'd3
  } op_e;

  // register word indexes on the config port
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_RISE   = 2'd2;
  localparam logic [1:0] REG_FALL   = 2'd3;

  // policy codes
  localparam logic POLICY_RR = 1'b0;
  localparam logic POLICY_LC = 1'b1;

  // register reset values
  localparam logic [3:0] RISE_RESET = 4'd2;
  localparam logic [3:0] FALL_RESET = 4'd3;

  // configuration seen by every cell
  typedef struct packed {
    logic       policy;
    logic [4:0] count;
    logic [3:0] rise;
    logic [3:0] fall;
  } cfg_t;

  // item token passed along the chain of cells
  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [3:0] idx;
    logic       passed;
    logic       in_range;
    logic       flipped;
    logic       hi_found;   // RR: healthy at/after cursor; LC: best so far
    logic       lo_found;   // RR: healthy before cursor
  } token_t;

  // one result item
  typedef struct packed {
    logic       pick_valid;
    logic [3:0] picked;
    logic       flipped;
    logic       in_range;
  } res_t;

endpackage

`default_nettype wire

// ----- design/backend_selector_with_health.sv -----
// The item token walks the chain of backend cells one cell per cycle; its result
//   then goes to the output register, or to the holding slot while out stalls.
// One item at a time: input stalls until its result reaches the output register.
// A finished result waits in the output register while the next item enters.
// Reset (rst_ni low, asynchronous): all backends healthy, counts and streaks
//   zero, cursor zero, registers at their reset values.
// ----------------------------------------------------------------------------
// backend_selector_with_health: health tracking backend selector
// Round robin or least connections pick over a chain of backend cells, with
// health reports and connection open and close events, and an APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module backend_selector_with_health #(
  parameter int unsigned MAX_BACKENDS = 16,
  parameter int unsigned LIVE_BITS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [3:0]  backend_index_i,
  input  wire logic        check_passed_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             pick_valid_o,
  output logic [3:0]       picked_backend_o,
  output logic             health_flipped_o,
  output logic             index_in_range_o,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int unsigned CW = $clog2(MAX_BACKENDS + 1);

  // config registers
  bsh_pkg::cfg_t cfg_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy <= bsh_pkg::POLICY_RR;
      cfg_q.count  <= 5'd0;
      cfg_q.rise   <= bsh_pkg::RISE_RESET;
      cfg_q.fall   <= bsh_pkg::FALL_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bsh_pkg::REG_POLICY: cfg_q.policy <= pwdata[0];
        bsh_pkg::REG_COUNT:  cfg_q.count  <= pwdata[4:0];
        bsh_pkg::REG_RISE:   cfg_q.rise   <= pwdata[3:0];
        bsh_pkg::REG_FALL:   cfg_q.fall   <= pwdata[3:0];
        default:             cfg_q        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bsh_pkg::REG_POLICY: prdata = {31'd0, cfg_q.policy};
      bsh_pkg::REG_COUNT:  prdata = {27'd0, cfg_q.count};
      bsh_pkg::REG_RISE:   prdata = {28'd0, cfg_q.rise};
      bsh_pkg::REG_FALL:   prdata = {28'd0, cfg_q.fall};
      default:             prdata = 32'd0;
    endcase
  end

  // effective backend count, clamped to capacity
  logic [CW-1:0] n_eff;
  assign n_eff = (32'(cfg_q.count) > 32'(MAX_BACKENDS)) ? CW'(MAX_BACKENDS)
                                                        : CW'(cfg_q.count);

  // cursor and item acceptance
  logic [IW-1:0] cursor_q, cursor_d;
  logic [IW-1:0] cur_eff;
  logic          busy_q, busy_d;
  logic          in_acc;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign cur_eff    = (32'(cursor_q) >= 32'(n_eff)) ? '0 : cursor_q;

  // chain of cells
  bsh_pkg::token_t      tok   [MAX_BACKENDS+1];
  logic [IW-1:0]        cur   [MAX_BACKENDS+1];
  logic [IW-1:0]        hi_ix [MAX_BACKENDS+1];
  logic [IW-1:0]        lo_ix [MAX_BACKENDS+1];
  logic [LIVE_BITS-1:0] blive [MAX_BACKENDS+1];

  always_comb begin
    tok[0].valid    = in_acc;
    tok[0].op       = bsh_pkg::op_e'(operation_i);
    tok[0].idx      = backend_index_i;
    tok[0].passed   = check_passed_i;
    tok[0].in_range = 32'(backend_index_i) < 32'(n_eff);
    tok[0].flipped  = 1'b0;
    tok[0].hi_found = 1'b0;
    tok[0].lo_found = 1'b0;
  end
  assign cur[0]   = cur_eff;
  assign hi_ix[0] = '0;
  assign lo_ix[0] = '0;
  assign blive[0] = '0;

  for (genvar k = 0; k < MAX_BACKENDS; k++) begin : g_cell
    bsh_cell #(
      .IW        (IW),
      .CW        (CW),
      .LIVE_BITS (LIVE_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg_q),
      .n_i         (n_eff),
      .tok_i       (tok[k]),
      .cur_i       (cur[k]),
      .hi_idx_i    (hi_ix[k]),
      .lo_idx_i    (lo_ix[k]),
      .best_live_i (blive[k]),
      .tok_o       (tok[k+1]),
      .cur_o       (cur[k+1]),
      .hi_idx_o    (hi_ix[k+1]),
      .lo_idx_o    (lo_ix[k+1]),
      .best_live_o (blive[k+1])
    );
  end

  // resolve the token leaving the last cell
  bsh_pkg::token_t last;
  bsh_pkg::res_t   res;
  logic            found;
  logic [IW-1:0]   chosen;
  logic [CW-1:0]   next_cur;
  logic [31:0]     chosen_w;

  assign last = tok[MAX_BACKENDS];

  always_comb begin
    if (cfg_q.policy == bsh_pkg::POLICY_RR) begin
      found  = last.hi_found || last.lo_found;
      chosen = last.hi_found ? hi_ix[MAX_BACKENDS] : lo_ix[MAX_BACKENDS];
    end else begin
      found  = last.hi_found;
      chosen = hi_ix[MAX_BACKENDS];
    end
    if (last.op != bsh_pkg::OP_PICK) found = 1'b0;
    next_cur = CW'(chosen) + CW'(1);
    chosen_w = found ? 32'(chosen) : 32'd0;
    res.pick_valid = found;
    res.picked     = chosen_w[3:0];
    res.flipped    = last.flipped;
    res.in_range   = last.in_range;
  end

  // cursor moves past the pick, or settles at the wrapped start
  always_comb begin
    cursor_d = cursor_q;
    if (last.valid && (last.op == bsh_pkg::OP_PICK) &&
        (cfg_q.policy == bsh_pkg::POLICY_RR) && (n_eff != '0)) begin
      if (found) cursor_d = (next_cur >= n_eff) ? '0 : IW'(next_cur);
      else       cursor_d = cur[MAX_BACKENDS];
    end
  end

  // output register with a one-entry holding slot
  bsh_pkg::res_t out_q, out_d, pend_q, pend_d;
  logic          out_vld_q, out_vld_d, pend_vld_q, pend_vld_d;
  logic          out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    busy_d     = busy_q || in_acc;
    if (pend_vld_q && out_free) begin
      out_d      = pend_q;
      out_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
      busy_d     = 1'b0;
    end else if (last.valid) begin
      if (out_free) begin
        out_d     = res;
        out_vld_d = 1'b1;
        busy_d    = 1'b0;
      end else begin
        pend_d     = res;
        pend_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q   <= '0;
      busy_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      cursor_q   <= cursor_d;
      busy_q     <= busy_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o      = out_vld_q;
  assign pick_valid_o     = out_q.pick_valid;
  assign picked_backend_o = out_q.picked;
  assign health_flipped_o = out_q.flipped;
  assign index_in_range_o = out_q.in_range;

endmodule

`default_nettype wire

// ----- design/bsh_cell.sv -----
// ----------------------------------------------------------------------------
// bsh_cell: one backend entry of the selector chain
// Holds the health flag, streaks and live count of one backend, applies the
// item token as it passes and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh_cell #(
  parameter int unsigned IW        = 4,
  parameter int unsigned CW        = 5,
  parameter int unsigned LIVE_BITS = 16,
  parameter int unsigned CELL_IDX  = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bsh_pkg::cfg_t         cfg_i,
  input  wire logic [CW-1:0]         n_i,
  input  wire bsh_pkg::token_t       tok_i,
  input  wire logic [IW-1:0]         cur_i,
  input  wire logic [IW-1:0]         hi_idx_i,
  input  wire logic [IW-1:0]         lo_idx_i,
  input  wire logic [LIVE_BITS-1:0]  best_live_i,
  output bsh_pkg::token_t            tok_o,
  output logic [IW-1:0]              cur_o,
  output logic [IW-1:0]              hi_idx_o,
  output logic [IW-1:0]              lo_idx_o,
  output logic [LIVE_BITS-1:0]       best_live_o
);

  localparam logic [IW-1:0]        MY_IDX   = IW'(CELL_IDX);
  localparam logic [LIVE_BITS-1:0] LIVE_MAX = {LIVE_BITS{1'b1}};

  // entry state
  logic                 healthy_q, healthy_d;
  logic [3:0]           pass_q, pass_d;
  logic [3:0]           fail_q, fail_d;
  logic [LIVE_BITS-1:0] live_q, live_d;

  // token stage
  bsh_pkg::token_t      tok_q, tok_d;
  logic [IW-1:0]        cur_q, hi_idx_q, hi_idx_d, lo_idx_q, lo_idx_d;
  logic [LIVE_BITS-1:0] best_live_q, best_live_d;

  logic       active;
  logic       addressed;
  logic [3:0] pass_inc;
  logic [3:0] fail_inc;

  assign active    = 32'(CELL_IDX) < 32'(n_i);
  assign addressed = tok_i.valid && active && (32'(tok_i.idx) == 32'(CELL_IDX));
  assign pass_inc  = pass_q + 4'd1;
  assign fail_inc  = fail_q + 4'd1;

  // entry update and token accumulation
  always_comb begin
    healthy_d   = healthy_q;
    pass_d      = pass_q;
    fail_d      = fail_q;
    live_d      = live_q;
    tok_d       = tok_i;
    hi_idx_d    = hi_idx_i;
    lo_idx_d    = lo_idx_i;
    best_live_d = best_live_i;

    case (tok_i.op)
      bsh_pkg::OP_PICK: begin
        if (tok_i.valid && active && healthy_q) begin
          if (cfg_i.policy == bsh_pkg::POLICY_RR) begin
            // first healthy at or after the cursor, else first before it
            if (MY_IDX >= cur_i) begin
              if (!tok_i.hi_found) begin
                tok_d.hi_found = 1'b1;
                hi_idx_d       = MY_IDX;
              end
            end else if (!tok_i.lo_found) begin
              tok_d.lo_found = 1'b1;
              lo_idx_d       = MY_IDX;
            end
          end else begin
            // lowest live count, ties to the lower index
            if (!tok_i.hi_found || (live_q < best_live_i)) begin
              tok_d.hi_found = 1'b1;
              hi_idx_d       = MY_IDX;
              best_live_d    = live_q;
            end
          end
        end
      end
      bsh_pkg::OP_HEALTH: begin
        if (addressed) begin
          if (tok_i.passed) begin
            fail_d = 4'd0;
            if (!healthy_q) begin
              pass_d = pass_inc;
              if (pass_inc >= cfg_i.rise) begin
                healthy_d     = 1'b1;
                pass_d        = 4'd0;
                tok_d.flipped = 1'b1;
              end
            end
          end else begin
            pass_d = 4'd0;
            if (healthy_q) begin
              fail_d = fail_inc;
              if (fail_inc >= cfg_i.fall) begin
                healthy_d     = 1'b0;
                fail_d        = 4'd0;
                tok_d.flipped = 1'b1;
              end
            end
          end
        end
      end
      bsh_pkg::OP_OPEN: begin
        if (addressed && (live_q != LIVE_MAX)) live_d = live_q + 1'b1;
      end
      bsh_pkg::OP_CLOSE: begin
        if (addressed && (live_q != '0)) live_d = live_q - 1'b1;
      end
      default: begin
        live_d = live_q;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      healthy_q   <= 1'b1;
      pass_q      <= 4'd0;
      fail_q      <= 4'd0;
      live_q      <= '0;
      tok_q       <= '0;
      cur_q       <= '0;
      hi_idx_q    <= '0;
      lo_idx_q    <= '0;
      best_live_q <= '0;
    end else begin
      healthy_q   <= healthy_d;
      pass_q      <= pass_d;
      fail_q      <= fail_d;
      live_q      <= live_d;
      tok_q       <= tok_d;
      cur_q       <= cur_i;
      hi_idx_q    <= hi_idx_d;
      lo_idx_q    <= lo_idx_d;
      best_live_q <= best_live_d;
    end
  end

  assign tok_o       = tok_q;
  assign cur_o       = cur_q;
  assign hi_idx_o    = hi_idx_q;
  assign lo_idx_o    = lo_idx_q;
  assign best_live_o = best_live_q;

endmodule

`default_nettype wire

// ----- design/bsh_checker.sv -----
// ----------------------------------------------------------------------------
// bsh_checker: port level checks of the backend selector
// Watches the item channels of the top level and reports slips by $error.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       pick_valid_o,
  input wire logic [3:0] picked_backend_o,
  input wire logic       health_flipped_o,
  input wire logic       index_in_range_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({pick_valid_o, picked_backend_o, health_flipped_o, index_in_range_o}))
    else $error("stalled result item changed");

  // one item at a time: an accepted item closes the input
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // a result item without a valid pick reports backend zero
  a_pick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pick_valid_o |-> picked_backend_o == 4'd0)
    else $error("picked backend set without a valid pick");

  // a flip comes only from a health report on an in-range backend
  a_flip_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && health_flipped_o |-> index_in_range_o && !pick_valid_o)
    else $error("health flip on a pick or out of range backend");

endmodule

bind backend_selector_with_health bsh_checker u_bsh_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .pick_valid_o     (pick_valid_o),
  .picked_backend_o (picked_backend_o),
  .health_flipped_o (health_flipped_o),
  .index_in_range_o (index_in_range_o)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: checks for the health tracking backend selector
// Sends picks, health reports and connection open and close items through a
// range of register settings, predicts each result item in a scoreboard and
// compares every result field by field, in order, against that prediction.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned NB           = 16;
  localparam int unsigned LIVE_BITS    = 16;
  localparam int unsigned LATENCY      = NB + 4;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 1280;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned RUN_OPENS    = 200;
  localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

  // Scoreboard: mirror of the backend table and the registers, plus the
  // queue of result items still owed by the block
  class pick_scoreboard;
    logic                 policy;
    logic [4:0]           count;
    logic [3:0]           rise;
    logic [3:0]           fall;
    logic [3:0]           cursor;
    logic                 healthy [NB];
    logic [LIVE_BITS-1:0] live [NB];
    logic [3:0]           pass_run [NB];
    logic [3:0]           fail_run [NB];
    bsh_pkg::res_t        expected_answers [$];
    int unsigned          errors, answers, valid_picks, flips;

    function new();
      policy = bsh_pkg::POLICY_RR;
      count  = '0;
      rise   = bsh_pkg::RISE_RESET;
      fall   = bsh_pkg::FALL_RESET;
      cursor = '0;
      foreach (healthy[i]) begin
        healthy[i]  = 1'b1;
        live[i]     = '0;
        pass_run[i] = '0;
        fail_run[i] = '0;
      end
      errors      = 0;
      answers     = 0;
      valid_picks = 0;
      flips       = 0;
    endfunction

    function void set_register(logic [1:0] which, logic [31:0] value);
      case (which)
        bsh_pkg::REG_POLICY: policy = value[0];
        bsh_pkg::REG_COUNT:  count  = value[4:0];
        bsh_pkg::REG_RISE:   rise   = value[3:0];
        bsh_pkg::REG_FALL:   fall   = value[3:0];
        default: ;
      endcase
    endfunction

    // count above capacity is clamped to the table size
    function int unsigned in_use();
      return (count > NB) ? NB : int'(count);
    endfunction

    // pick a healthy backend under the current policy
    function bit choose_backend(output logic [3:0] chosen);
      int unsigned n, at;
      bit found;
      n      = in_use();
      chosen = '0;
      found  = 1'b0;
      if (n == 0) return 1'b0;
      if (policy == bsh_pkg::POLICY_RR) begin
        // a stale cursor wraps before the scan
        if (cursor >= n) cursor = '0;
        for (int i = 0; i < n; i++) begin
          at     = cursor;
          cursor = (cursor + 1 >= n) ? 4'd0 : cursor + 4'd1;
          if (healthy[at]) begin
            chosen = at[3:0];
            return 1'b1;
          end
        end
        return 1'b0;
      end
      // least connections, ties to the lower index
      for (int i = 0; i < n; i++) begin
        if (healthy[i] && (!found || live[i] < live[chosen])) begin
          chosen = i[3:0];
          found  = 1'b1;
        end
      end
      return found;
    endfunction

    // streak counting; a pass while up or a fail while down only clears
    // the opposite streak
    function bit apply_health(logic [3:0] idx, logic passed);
      if (passed) begin
        fail_run[idx] = '0;
        if (!healthy[idx]) begin
          pass_run[idx] = pass_run[idx] + 4'd1;
          if (pass_run[idx] >= rise) begin
            healthy[idx]  = 1'b1;
            pass_run[idx] = '0;
            return 1'b1;
          end
        end
      end else begin
        pass_run[idx] = '0;
        if (healthy[idx]) begin
          fail_run[idx] = fail_run[idx] + 4'd1;
          if (fail_run[idx] >= fall) begin
            healthy[idx]  = 1'b0;
            fail_run[idx] = '0;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    // an accepted input item: update the mirror, queue its result
    function void accept_request(bsh_pkg::op_e op, logic [3:0] idx, logic passed);
      bsh_pkg::res_t r;
      logic [3:0]    chosen;
      r          = '0;
      r.in_range = (idx < in_use());
      case (op)
        bsh_pkg::OP_PICK: begin
          r.pick_valid = choose_backend(chosen);
          if (r.pick_valid) r.picked = chosen;
        end
        bsh_pkg::OP_HEALTH: if (r.in_range) r.flipped = apply_health(idx, passed);
        bsh_pkg::OP_OPEN:
          if (r.in_range && live[idx] != '1) live[idx] = live[idx] + 1'b1;
        bsh_pkg::OP_CLOSE:
          if (r.in_range && live[idx] != '0) live[idx] = live[idx] - 1'b1;
        default: ;
      endcase
      expected_answers.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_answer(bsh_pkg::res_t got);
      bsh_pkg::res_t want;
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: expected none, actual %b", $time, got);
        return;
      end
      want = expected_answers.pop_front();
      answers++;
      if (want.pick_valid) valid_picks++;
      if (want.flipped) flips++;
      check_field("pick_valid", 32'(want.pick_valid), 32'(got.pick_valid));
      check_field("picked_backend", 32'(want.picked), 32'(got.picked));
      check_field("health_flipped", 32'(want.flipped), 32'(got.flipped));
      check_field("index_in_range", 32'(want.in_range), 32'(got.in_range));
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i      = bsh_pkg::OP_PICK;
  logic [3:0]  backend_index_i  = '0;
  logic        check_passed_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic        pick_valid_o;
  logic [3:0]  picked_backend_o;
  logic        health_flipped_o;
  logic        index_in_range_o;
  logic        psel             = 1'b0;
  logic        penable          = 1'b0;
  logic        pwrite           = 1'b0;
  logic [3:0]  paddr            = '0;
  logic [31:0] pwdata           = '0;
  logic [31:0] prdata;
  logic        pready;

  pick_scoreboard  sb;
  bit              relaxed      = 1'b0;  // no idling on either side
  bit              hold_request = 1'b0;  // ask the receiver for a long hold
  int unsigned     items_sent   = 0;
  longint unsigned cycle_count  = 0;

  backend_selector_with_health u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .backend_index_i  (backend_index_i),
    .check_passed_i   (check_passed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pick_valid_o     (pick_valid_o),
    .picked_backend_o (picked_backend_o),
    .health_flipped_o (health_flipped_o),
    .index_in_range_o (index_in_range_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_answer({pick_valid_o, picked_backend_o, health_flipped_o, index_in_range_o});
  end

  // result receiver: random stalls, or one long hold on request
  initial begin
    int unsigned held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request && held < HOLD_CYCLES) begin
        out_stall_i = 1'b1;
        held++;
      end else begin
        hold_request = 1'b0;
        held         = 0;
        out_stall_i  = !relaxed && ($urandom_range(0, 99) < 22);
      end
    end
  end

  // offer one item, hold it until accepted
  task automatic send_item(bsh_pkg::op_e op, logic [3:0] idx, logic passed);
    int unsigned gap;
    gap = (!relaxed && $urandom_range(0, 99) < 22) ? $urandom_range(1, 24) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    operation_i     = op;
    backend_index_i = idx;
    check_passed_i  = passed;
    do @(posedge clk_i); while (in_stall_o);
    sb.accept_request(op, idx, passed);
    items_sent++;
  endtask

  // stop offering and let every owed result come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // APB write, then read back
  task automatic program_reg(logic [1:0] which, logic [31:0] value);
    logic [31:0] mask;
    case (which)
      bsh_pkg::REG_POLICY: mask = 32'h1;
      bsh_pkg::REG_COUNT:  mask = 32'h1f;
      default:             mask = 32'hf;
    endcase
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {which, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(which, value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.check_field("register readback", value & mask, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(logic policy, logic [4:0] count, logic [3:0] rise,
                           logic [3:0] fall);
    program_reg(bsh_pkg::REG_POLICY, {31'd0, policy});
    program_reg(bsh_pkg::REG_COUNT, {27'd0, count});
    program_reg(bsh_pkg::REG_RISE, {28'd0, rise});
    program_reg(bsh_pkg::REG_FALL, {28'd0, fall});
  endtask

  // random bursts: health streaks, connection runs, picks and some noise
  task automatic run_random(int unsigned budget);
    int unsigned  done_cnt, len, kind, n;
    logic [3:0]   idx;
    logic         passed;
    bsh_pkg::op_e op;
    done_cnt = 0;
    n        = sb.in_use();
    while (done_cnt < budget) begin
      kind   = $urandom_range(0, 99);
      idx    = (n != 0 && $urandom_range(0, 9) < 8) ? 4'($urandom_range(0, n - 1))
                                                    : 4'($urandom_range(0, 15));
      passed = 1'($urandom_range(0, 1));
      if (kind < 35) begin
        op  = bsh_pkg::OP_HEALTH;
        len = $urandom_range(1, 16);
      end else if (kind < 55) begin
        op  = bsh_pkg::OP_OPEN;
        len = $urandom_range(1, 8);
      end else if (kind < 65) begin
        op  = bsh_pkg::OP_CLOSE;
        len = $urandom_range(1, 8);
      end else begin
        op  = bsh_pkg::OP_PICK;
        len = $urandom_range(1, 4);
      end
      repeat (len) begin
        if (kind >= 90) begin
          op     = bsh_pkg::op_e'($urandom_range(0, 3));
          idx    = 4'($urandom_range(0, 15));
          passed = 1'($urandom_range(0, 1));
        end else if (op == bsh_pkg::OP_HEALTH && $urandom_range(0, 99) < 15) begin
          passed = !passed;  // break the streak now and then
        end
        send_item(op, idx, passed);
        if (op == bsh_pkg::OP_PICK || idx < n) done_cnt++;
      end
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: no backends at all
    send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    send_item(bsh_pkg::OP_HEALTH, 4'd0, 1'b0);
    send_item(bsh_pkg::OP_OPEN, 4'd15, 1'b1);
    drain();

    // round robin over four, fast thresholds
    configure(bsh_pkg::POLICY_RR, 5'd4, 4'd1, 4'd2);
    repeat (5) send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    repeat (2) send_item(bsh_pkg::OP_HEALTH, 4'd1, 1'b0);
    repeat (4) send_item(bsh_pkg::OP_PICK, 4'd15, 1'b1);
    repeat (2) send_item(bsh_pkg::OP_HEALTH, 4'd1, 1'b1);
    send_item(bsh_pkg::OP_OPEN, 4'd3, 1'b0);
    repeat (2) send_item(bsh_pkg::OP_CLOSE, 4'd3, 1'b1);
    send_item(bsh_pkg::OP_OPEN, 4'd4, 1'b0);
    send_item(bsh_pkg::OP_HEALTH, 4'd15, 1'b0);
    drain();

    // shrink below the cursor
    configure(bsh_pkg::POLICY_RR, 5'd2, bsh_pkg::RISE_RESET, bsh_pkg::FALL_RESET);
    send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    drain();

    // least connections, count past capacity, zero thresholds
    configure(bsh_pkg::POLICY_LC, 5'd31, 4'd0, 4'd0);
    send_item(bsh_pkg::OP_OPEN, 4'd0, 1'b0);
    send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    send_item(bsh_pkg::OP_HEALTH, 4'd1, 1'b0);
    send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    send_item(bsh_pkg::OP_HEALTH, 4'd1, 1'b1);
    send_item(bsh_pkg::OP_HEALTH, 4'd15, 1'b0);
    send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    drain();

    // long run of opens on one backend, full rate on both sides
    configure(bsh_pkg::POLICY_LC, 5'd2, bsh_pkg::RISE_RESET, bsh_pkg::FALL_RESET);
    relaxed = 1'b1;
    repeat (RUN_OPENS) send_item(bsh_pkg::OP_OPEN, 4'd0, 1'b1);
    repeat (2) send_item(bsh_pkg::OP_OPEN, 4'd1, 1'b1);
    send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    send_item(bsh_pkg::OP_CLOSE, 4'd0, 1'b0);
    send_item(bsh_pkg::OP_PICK, 4'd0, 1'b0);
    drain();
    relaxed = 1'b0;

    // random phases across settings; one phase with a long receiver hold
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(bsh_pkg::POLICY_RR, 5'd16, 4'd1, 4'd1);
        1: configure(bsh_pkg::POLICY_LC, 5'd16, 4'd15, 4'd15);
        2: configure(bsh_pkg::POLICY_RR, 5'd31, 4'd0, 4'd15);
        3: configure(bsh_pkg::POLICY_LC, 5'd1, 4'd15, 4'd0);
        default: configure(1'($urandom_range(0, 1)),
                           ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                                       : 5'($urandom_range(0, 16)),
                           4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      if (ph == 2) hold_request = 1'b1;
      run_random(RANDOM_ITEMS / PHASES);
      drain();
    end

    $display("covered %0d items over %0d register setups, with a long full-rate open run",
             items_sent, PHASES + 5);
    $display("results checked %0d, healthy picks %0d, health flips %0d",
             sb.answers, sb.valid_picks, sb.flips);
    if (sb.errors == 0 && sb.expected_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bsh_pkg.sv
design/bsh_cell.sv
design/backend_selector_with_health.sv
design/bsh_checker.sv
test/testbench.sv
